### design/rrtt_pkg.sv
package rrtt_pkg;

    localparam int THREAD_SLOTS = 128;
    localparam int SLOT_W       = $clog2(THREAD_SLOTS);
    localparam int KIND_W       = 2;
    localparam int FIELD_W      = 7;
    localparam int OUTCOME_W    = 3;

    // slots examined per scan cycle
    localparam int CHUNK     = (THREAD_SLOTS < 16) ? THREAD_SLOTS : 16;
    localparam int NCHUNK    = (THREAD_SLOTS + CHUNK - 1) / CHUNK;
    localparam int PAD_SLOTS = NCHUNK * CHUNK;
    localparam int CHUNK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [PAD_SLOTS-1:0] SLOT_MASK =
        {PAD_SLOTS{1'b1}} >> (PAD_SLOTS - THREAD_SLOTS);

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [PAD_SLOTS-1:0] t_vec;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_CREATE = 2'd1,
        KIND_EXIT   = 2'd2,
        KIND_JOIN   = 2'd3
    } t_kind;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_OK         = 3'd0,
        OC_FULL       = 3'd1,
        OC_NOSUCH     = 3'd2,
        OC_NONE_READY = 3'd3,
        OC_ALL_DONE   = 3'd4
    } t_outcome;

    typedef struct packed {
        logic load;
        logic start;
        logic scan_clr;
        logic scan_step;
        logic scan_empty;
        logic claim;
        logic prep;
        logic apply;
        logic jrd;
        logic exit_upd;
        logic join_upd;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic empty_found;
        logic join_live;
        logic out_busy;
    } t_sts;

endpackage

### design/rrtt_ctrl.sv
module rrtt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rrtt_pkg::KIND_W-1:0] i_kind,
    output logic                       o_ready,
    output rrtt_pkg::t_cmd             o_cmd,
    input  rrtt_pkg::t_sts             i_sts
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_START  = 11'b000_0000_0010,
        S_SCAN_E = 11'b000_0000_0100,
        S_CLAIM  = 11'b000_0000_1000,
        S_PREP   = 11'b000_0001_0000,
        S_SCAN_P = 11'b000_0010_0000,
        S_APPLY  = 11'b000_0100_0000,
        S_JRD    = 11'b000_1000_0000,
        S_EXIT   = 11'b001_0000_0000,
        S_JOIN   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (rrtt_pkg::t_kind'(i_kind))
                        rrtt_pkg::KIND_TICK:   n_state = S_PREP;
                        rrtt_pkg::KIND_CREATE: n_state = S_START;
                        rrtt_pkg::KIND_EXIT:   n_state = S_JRD;
                        rrtt_pkg::KIND_JOIN:   n_state = S_JOIN;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_START: begin
                o_cmd.start    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN_E;
            end
            S_SCAN_E: begin
                o_cmd.scan_step  = 1'b1;
                o_cmd.scan_empty = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_CLAIM;
                end
            end
            S_CLAIM: begin
                o_cmd.claim = 1'b1;
                n_state     = i_sts.empty_found ? S_PREP : S_DONE;
            end
            S_PREP: begin
                o_cmd.prep     = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN_P;
            end
            S_SCAN_P: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_DONE;
            end
            S_JRD: begin
                o_cmd.jrd = 1'b1;
                n_state   = S_EXIT;
            end
            S_EXIT: begin
                o_cmd.exit_upd = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN_P;
            end
            S_JOIN: begin
                o_cmd.join_upd = 1'b1;
                n_state        = i_sts.join_live ? S_PREP : S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_push_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> !i_sts.out_busy)
        else $error("result pushed over a pending result");

    a_scan_exit_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_P && !i_sts.scan_last) |=> (r_state == S_SCAN_P))
        else $error("pick scan left early");

    a_load_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != S_IDLE))
        else $error("request taken without processing");

endmodule

### design/rrtt_dp.sv
module rrtt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrtt_pkg::t_cmd                i_cmd,
    output rrtt_pkg::t_sts                o_sts,
    input  logic [rrtt_pkg::KIND_W-1:0]   i_kind,
    input  logic [rrtt_pkg::FIELD_W-1:0]  i_target,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [rrtt_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [rrtt_pkg::FIELD_W-1:0]  o_new_slot,
    output logic [rrtt_pkg::FIELD_W-1:0]  o_running_slot
);

    // status flags per slot; a slot with no flag set is empty
    rrtt_pkg::t_vec r_rdy, r_blk, r_dead, r_run;
    rrtt_pkg::t_vec n_rdy, n_blk, n_dead, n_run;
    logic [rrtt_pkg::THREAD_SLOTS-1:0] r_jval, n_jval;
    rrtt_pkg::t_slot r_joiner [rrtt_pkg::THREAD_SLOTS];
    rrtt_pkg::t_slot r_jdata;
    logic            r_jhit;

    rrtt_pkg::t_kind   r_kind;
    logic [rrtt_pkg::FIELD_W-1:0] r_target;
    rrtt_pkg::t_slot   r_cur, n_cur;
    logic              r_started, n_started;
    rrtt_pkg::t_outcome r_outcome, n_outcome;
    logic [rrtt_pkg::FIELD_W-1:0] r_new, n_new;

    logic [rrtt_pkg::CHUNK_W-1:0] r_chunk;
    logic            r_hi_found, r_any_found, r_live;
    rrtt_pkg::t_slot r_hi_idx, r_any_idx;

    logic                          r_out_valid;
    rrtt_pkg::t_outcome            r_out_outcome;
    logic [rrtt_pkg::FIELD_W-1:0]  r_out_new;
    logic [rrtt_pkg::FIELD_W-1:0]  r_out_run;

    logic            tgt_ok;
    rrtt_pkg::t_slot tgt_idx;
    logic            tgt_live;
    rrtt_pkg::t_slot waker;
    rrtt_pkg::t_slot pick_idx;
    logic            scan_last;

    logic [rrtt_pkg::CHUNK-1:0] c_search;
    logic [rrtt_pkg::CHUNK-1:0] c_live;
    logic            hi_hit, any_hit;
    rrtt_pkg::t_slot hi_pos, any_pos;

    assign tgt_ok    = int'(r_target) < rrtt_pkg::THREAD_SLOTS;
    assign tgt_idx   = rrtt_pkg::SLOT_W'(r_target);
    assign tgt_live  = r_rdy[tgt_idx] | r_blk[tgt_idx] | r_run[tgt_idx];
    assign waker     = r_jhit ? r_jdata : r_cur;
    assign pick_idx  = r_hi_found ? r_hi_idx : r_any_idx;
    assign scan_last = (r_chunk == rrtt_pkg::CHUNK_W'(rrtt_pkg::NCHUNK - 1));

    assign o_sts.scan_last   = scan_last;
    assign o_sts.empty_found = r_any_found;
    assign o_sts.join_live   = tgt_ok & tgt_live;
    assign o_sts.out_busy    = r_out_valid & ~i_ready;

    // chunk search: lowest hit, and lowest hit above the running slot
    always_comb begin
        int base;
        rrtt_pkg::t_vec v_empty;
        base     = int'(r_chunk) * rrtt_pkg::CHUNK;
        v_empty  = ~(r_rdy | r_blk | r_dead | r_run) & rrtt_pkg::SLOT_MASK;
        v_empty[0] = 1'b0;
        c_search = i_cmd.scan_empty ? v_empty[base +: rrtt_pkg::CHUNK]
                                    : r_rdy[base +: rrtt_pkg::CHUNK];
        c_live   = r_rdy[base +: rrtt_pkg::CHUNK] | r_blk[base +: rrtt_pkg::CHUNK] |
                   r_run[base +: rrtt_pkg::CHUNK];
        hi_hit   = 1'b0;
        any_hit  = 1'b0;
        hi_pos   = '0;
        any_pos  = '0;
        for (int b = rrtt_pkg::CHUNK - 1; b >= 0; b--) begin
            if (c_search[b]) begin
                any_hit = 1'b1;
                any_pos = rrtt_pkg::SLOT_W'(base + b);
                if (base + b > int'(r_cur)) begin
                    hi_hit = 1'b1;
                    hi_pos = rrtt_pkg::SLOT_W'(base + b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk     <= '0;
            r_hi_found  <= 1'b0;
            r_any_found <= 1'b0;
            r_live      <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_chunk     <= '0;
            r_hi_found  <= 1'b0;
            r_any_found <= 1'b0;
            r_live      <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (!scan_last) begin
                r_chunk <= r_chunk + 1'b1;
            end
            if (!r_hi_found && hi_hit) begin
                r_hi_found <= 1'b1;
            end
            if (!r_any_found && any_hit) begin
                r_any_found <= 1'b1;
            end
            r_live <= r_live | (|c_live);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && !r_hi_found && hi_hit) begin
            r_hi_idx <= hi_pos;
        end
        if (i_cmd.scan_step && !r_any_found && any_hit) begin
            r_any_idx <= any_pos;
        end
    end

    // table updates
    always_comb begin
        n_rdy     = r_rdy;
        n_blk     = r_blk;
        n_dead    = r_dead;
        n_run     = r_run;
        n_jval    = r_jval;
        n_cur     = r_cur;
        n_started = r_started;
        n_outcome = r_outcome;
        n_new     = r_new;
        if (i_cmd.load) begin
            n_outcome = rrtt_pkg::OC_OK;
            n_new     = '0;
        end
        if (i_cmd.start && !r_started) begin
            n_rdy     = '0;
            n_blk     = '0;
            n_dead    = '0;
            n_run     = '0;
            n_jval    = '0;
            n_rdy[0]  = 1'b1;
            n_started = 1'b1;
        end
        if (i_cmd.claim) begin
            if (r_any_found) begin
                n_rdy[r_any_idx]  = 1'b1;
                n_jval[r_any_idx] = 1'b0;
                n_new             = rrtt_pkg::FIELD_W'(r_any_idx);
            end else begin
                n_outcome = rrtt_pkg::OC_FULL;
            end
        end
        if (i_cmd.prep && r_run[r_cur]) begin
            n_run[r_cur] = 1'b0;
            n_rdy[r_cur] = 1'b1;
        end
        if (i_cmd.exit_upd) begin
            n_rdy[r_cur]  = 1'b0;
            n_blk[r_cur]  = 1'b0;
            n_run[r_cur]  = 1'b0;
            n_dead[r_cur] = 1'b1;
            if (waker != r_cur) begin
                n_blk[waker]  = 1'b0;
                n_dead[waker] = 1'b0;
                n_run[waker]  = 1'b0;
                n_rdy[waker]  = 1'b1;
            end
        end
        if (i_cmd.join_upd) begin
            priority if (tgt_ok && tgt_live) begin
                n_rdy[r_cur]    = 1'b0;
                n_dead[r_cur]   = 1'b0;
                n_run[r_cur]    = 1'b0;
                n_blk[r_cur]    = 1'b1;
                n_jval[tgt_idx] = 1'b1;
            end else if (tgt_ok && r_dead[tgt_idx]) begin
                n_dead[tgt_idx] = 1'b0;
            end else begin
                n_outcome = rrtt_pkg::OC_NOSUCH;
            end
        end
        if (i_cmd.apply) begin
            priority if (r_kind == rrtt_pkg::KIND_EXIT && !r_live) begin
                n_outcome = rrtt_pkg::OC_ALL_DONE;
            end else if (r_hi_found || r_any_found) begin
                n_cur           = pick_idx;
                n_rdy[pick_idx] = 1'b0;
                n_run[pick_idx] = 1'b1;
            end else begin
                n_outcome = rrtt_pkg::OC_NONE_READY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy     <= '0;
            r_blk     <= '0;
            r_dead    <= '0;
            r_run     <= '0;
            r_jval    <= '0;
            r_cur     <= '0;
            r_started <= 1'b0;
        end else begin
            r_rdy     <= n_rdy;
            r_blk     <= n_blk;
            r_dead    <= n_dead;
            r_run     <= n_run;
            r_jval    <= n_jval;
            r_cur     <= n_cur;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_outcome <= n_outcome;
        r_new     <= n_new;
        if (i_cmd.load) begin
            r_kind   <= rrtt_pkg::t_kind'(i_kind);
            r_target <= i_target;
        end
    end

    // joiner memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.join_upd && tgt_ok && tgt_live) begin
            r_joiner[tgt_idx] <= r_cur;
        end
        if (i_cmd.jrd) begin
            r_jdata <= r_joiner[r_cur];
            r_jhit  <= r_jval[r_cur];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_outcome <= r_outcome;
            r_out_new     <= r_new;
            r_out_run     <= rrtt_pkg::FIELD_W'(r_cur);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_outcome      = r_out_outcome;
    assign o_new_slot     = r_out_new;
    assign o_running_slot = r_out_run;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_run))
        else $error("more than one running slot");

    a_running_is_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_run) |-> r_run[r_cur])
        else $error("running slot differs from current slot");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_rdy & r_blk) | (r_rdy & r_dead) | (r_blk & r_dead) |
         (r_run & (r_rdy | r_blk | r_dead))) == '0)
        else $error("slot holds two states");

    a_no_pad_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_rdy | r_blk | r_dead | r_run) & ~rrtt_pkg::SLOT_MASK) == '0)
        else $error("state flag beyond last slot");

    a_new_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_outcome != rrtt_pkg::OC_OK) |-> (r_out_new == '0))
        else $error("claimed slot reported on failed request");

endmodule

### design/round_robin_thread_table.sv
// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_kind, i_target
// result    out        o_valid / i_ready   o_outcome, o_new_slot, o_running_slot
//
// one request at a time; a result waits in an output register while the next request runs
// the slot scan examines 16 slots per cycle over 128 slots
// synchronous active-low reset empties the table; no clearing pass is needed
// a stalled result holds the following request only in its final state, S_DONE

module round_robin_thread_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rrtt_pkg::KIND_W-1:0]     i_kind,
    input  logic [rrtt_pkg::FIELD_W-1:0]    i_target,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rrtt_pkg::OUTCOME_W-1:0]  o_outcome,
    output logic [rrtt_pkg::FIELD_W-1:0]    o_new_slot,
    output logic [rrtt_pkg::FIELD_W-1:0]    o_running_slot
);

    rrtt_pkg::t_cmd cmd;
    rrtt_pkg::t_sts sts;

    rrtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    rrtt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_target       (i_target),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_outcome      (o_outcome),
        .o_new_slot     (o_new_slot),
        .o_running_slot (o_running_slot)
    );

endmodule

### tb/round_robin_thread_table_check.sv
module round_robin_thread_table_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [rrtt_pkg::KIND_W-1:0]     i_kind,
    input  logic [rrtt_pkg::FIELD_W-1:0]    i_target,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [rrtt_pkg::OUTCOME_W-1:0]  i_outcome,
    input  logic [rrtt_pkg::FIELD_W-1:0]    i_new_slot,
    input  logic [rrtt_pkg::FIELD_W-1:0]    i_running_slot,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rrtt_pkg::*;

    typedef enum logic [2:0] {
        TS_RUNNING = 3'd0,
        TS_READY   = 3'd1,
        TS_BLOCKED = 3'd2,
        TS_DEAD    = 3'd3,
        TS_EMPTY   = 3'd4
    } t_thread_state;

    typedef struct packed {
        t_outcome            outcome;
        logic [FIELD_W-1:0]  new_slot;
        logic [FIELD_W-1:0]  running_slot;
    } t_sched_result;

    t_thread_state  thread_state [THREAD_SLOTS];
    t_slot          joiner_of [THREAD_SLOTS];
    t_slot          running;
    logic           launched;
    t_sched_result  results_due [$];
    int             mismatches = 0;

    function automatic void wipe_table();
        for (int i = 0; i < THREAD_SLOTS; i++) begin
            thread_state[i] = TS_EMPTY;
            joiner_of[i]    = t_slot'(i);
        end
    endfunction

    function automatic logic is_alive(t_thread_state s);
        return s == TS_RUNNING || s == TS_READY || s == TS_BLOCKED;
    endfunction

    // round-robin scan after the running slot, ending on the running slot itself
    function automatic t_outcome rotate_to_ready();
        int idx;
        if (thread_state[running] == TS_RUNNING) thread_state[running] = TS_READY;
        idx = int'(running);
        for (int n = 0; n < THREAD_SLOTS; n++) begin
            idx = (idx == THREAD_SLOTS - 1) ? 0 : idx + 1;
            if (thread_state[idx] == TS_READY) begin
                running = t_slot'(idx);
                thread_state[idx] = TS_RUNNING;
                return OC_OK;
            end
        end
        return OC_NONE_READY;
    endfunction

    function automatic void schedule_event(
        input  t_kind               kind,
        input  logic [FIELD_W-1:0]  target,
        output t_outcome            outcome,
        output logic [FIELD_W-1:0]  claimed
    );
        int    free_idx;
        logic  any_live;
        t_slot waker;
        outcome = OC_OK;
        claimed = '0;
        case (kind)
            KIND_TICK: begin
                outcome = rotate_to_ready();
            end
            KIND_CREATE: begin
                if (!launched) begin
                    wipe_table();
                    thread_state[0] = TS_READY;
                    launched = 1'b1;
                end
                free_idx = 0;
                for (int i = THREAD_SLOTS - 1; i >= 1; i--)
                    if (thread_state[i] == TS_EMPTY) free_idx = i;
                if (free_idx == 0) begin
                    outcome = OC_FULL;
                end else begin
                    claimed = FIELD_W'(free_idx);
                    thread_state[free_idx] = TS_READY;
                    joiner_of[free_idx]    = t_slot'(free_idx);
                    outcome = rotate_to_ready();
                end
            end
            KIND_EXIT: begin
                waker = joiner_of[running];
                thread_state[running] = TS_DEAD;
                if (waker != running) thread_state[waker] = TS_READY;
                any_live = 1'b0;
                for (int i = 0; i < THREAD_SLOTS; i++)
                    if (is_alive(thread_state[i])) any_live = 1'b1;
                outcome = any_live ? rotate_to_ready() : OC_ALL_DONE;
            end
            default: begin
                if (int'(target) >= THREAD_SLOTS) begin
                    outcome = OC_NOSUCH;
                end else if (is_alive(thread_state[target])) begin
                    thread_state[running] = TS_BLOCKED;
                    joiner_of[target]     = running;
                    outcome = rotate_to_ready();
                end else if (thread_state[target] == TS_DEAD) begin
                    thread_state[target] = TS_EMPTY;
                end else begin
                    outcome = OC_NOSUCH;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_sched_result      entry;
        t_outcome           oc;
        logic [FIELD_W-1:0] claimed;
        if (!i_rst_n) begin
            wipe_table();
            running  = '0;
            launched = 1'b0;
            results_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding: outcome %0d, running_slot %0d",
                           i_outcome, i_running_slot);
                    mismatches++;
                end else begin
                    entry = results_due.pop_front();
                    if (i_outcome !== entry.outcome) begin
                        $error("outcome: expected %0d, actual %0d", entry.outcome, i_outcome);
                        mismatches++;
                    end
                    if (i_new_slot !== entry.new_slot) begin
                        $error("new_slot: expected %0d, actual %0d", entry.new_slot, i_new_slot);
                        mismatches++;
                    end
                    if (i_running_slot !== entry.running_slot) begin
                        $error("running_slot: expected %0d, actual %0d",
                               entry.running_slot, i_running_slot);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                schedule_event(t_kind'(i_kind), i_target, oc, claimed);
                entry.outcome      = oc;
                entry.new_slot     = claimed;
                entry.running_slot = FIELD_W'(running);
                results_due.push_back(entry);
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/round_robin_thread_table_tb.sv
module round_robin_thread_table_tb;
    import rrtt_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int EPISODE_LEN  = 20;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE       = 40;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  i_valid  = 1'b0;
    logic [KIND_W-1:0]     i_kind   = '0;
    logic [FIELD_W-1:0]    i_target = '0;
    logic                  i_ready  = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [OUTCOME_W-1:0]  o_outcome;
    logic [FIELD_W-1:0]    o_new_slot;
    logic [FIELD_W-1:0]    o_running_slot;

    int                    fail_count;
    int                    pending;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    int                    quiet_cycles = 0;
    logic [FIELD_W-1:0]    seen_running = '0;

    round_robin_thread_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_target       (i_target),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_outcome      (o_outcome),
        .o_new_slot     (o_new_slot),
        .o_running_slot (o_running_slot)
    );

    round_robin_thread_table_check table_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_kind         (i_kind),
        .i_target       (i_target),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_outcome      (o_outcome),
        .i_new_slot     (o_new_slot),
        .i_running_slot (o_running_slot),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (o_valid && i_ready) seen_running <= o_running_slot;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input t_kind kind, input logic [FIELD_W-1:0] target);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_target <= target;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // one request, then hold off until its result is back
    task automatic send_and_drain(input t_kind kind, input logic [FIELD_W-1:0] target);
        send_req(kind, target);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int                  sent;
        int                  episode;
        int                  mode;
        int                  r;
        t_kind               kind;
        logic [FIELD_W-1:0]  target;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // events on the untouched table
        send_and_drain(KIND_TICK,   7'd127);
        send_and_drain(KIND_JOIN,   7'd0);
        send_and_drain(KIND_JOIN,   7'd127);
        send_and_drain(KIND_EXIT,   7'd85);
        send_and_drain(KIND_JOIN,   7'd0);
        // first create, then exit everything to reach all done
        send_and_drain(KIND_CREATE, 7'd42);
        send_and_drain(KIND_CREATE, 7'd0);
        send_and_drain(KIND_JOIN,   7'd1);
        send_and_drain(KIND_EXIT,   7'd0);
        send_and_drain(KIND_EXIT,   7'd127);
        send_and_drain(KIND_EXIT,   7'd0);
        send_and_drain(KIND_TICK,   7'd0);
        // reap dead slots, then join an empty one
        send_and_drain(KIND_JOIN,   7'd1);
        send_and_drain(KIND_JOIN,   7'd2);
        send_and_drain(KIND_JOIN,   7'd0);
        send_and_drain(KIND_JOIN,   7'd2);
        send_and_drain(KIND_CREATE, 7'd127);
        send_and_drain(KIND_CREATE, 7'd0);
        send_and_drain(KIND_TICK,   7'd85);
        send_and_drain(KIND_JOIN,   7'd3);
        // self join
        send_and_drain(KIND_JOIN,   seen_running);
        send_and_drain(KIND_TICK,   7'd0);
        send_and_drain(KIND_EXIT,   7'd42);

        sent    = 0;
        episode = 0;
        while (sent < RANDOM_ITEMS) begin
            case ((episode / 2) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            mode = $urandom_range(0, 99);
            for (int n = 0; n < EPISODE_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (mode < 6) begin
                    // create burst, drives the table toward full
                    kind = KIND_CREATE;
                end else if (mode < 18) begin
                    // reaping: mostly joins over a wide target range
                    if (r < 60)      kind = KIND_JOIN;
                    else if (r < 80) kind = KIND_EXIT;
                    else             kind = KIND_TICK;
                end else begin
                    if (r < 25)      kind = KIND_TICK;
                    else if (r < 55) kind = KIND_CREATE;
                    else if (r < 85) kind = KIND_EXIT;
                    else             kind = KIND_JOIN;
                end
                r = $urandom_range(0, 19);
                if (kind == KIND_JOIN && r == 0)
                    target = seen_running;
                else if (r < 12 && mode >= 18)
                    target = FIELD_W'($urandom_range(0, 15));
                else
                    target = FIELD_W'($urandom_range(0, 127));
                send_req(kind, target);
                sent++;
            end
            episode++;
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
